/* hdl/twg_pkg.sv */
// Shared types, constants and helper functions for the twiddle gain tuner.
`default_nettype none

package twg_pkg;

  localparam int NUM_GAINS = 3;
  localparam int FRAC_BITS = 24;

  typedef logic signed [31:0] gain_t;
  typedef logic [30:0]        step_t;
  typedef logic [31:0]        err_t;
  typedef logic [1:0]         gidx_t;
  typedef logic [1:0]         phase_t;
  typedef logic [2:0]         reg_idx_t;
  typedef logic [31:0]        cfg_data_t;

  // Search phase codes
  localparam phase_t PH_START = 2'd0;
  localparam phase_t PH_PLUS  = 2'd1;
  localparam phase_t PH_MINUS = 2'd2;

  // Configuration register indexes
  localparam reg_idx_t REG_GAIN_P = 3'd0;
  localparam reg_idx_t REG_GAIN_I = 3'd1;
  localparam reg_idx_t REG_GAIN_D = 3'd2;
  localparam reg_idx_t REG_STEP_P = 3'd3;
  localparam reg_idx_t REG_STEP_I = 3'd4;
  localparam reg_idx_t REG_STEP_D = 3'd5;

  // Gain indexes
  localparam gidx_t GIDX_P = 2'd0;
  localparam gidx_t GIDX_I = 2'd1;
  localparam gidx_t GIDX_D = 2'd2;

  // Register reset values: 0.25, 0.0 and 30.0 for the gains
  localparam gain_t RST_GAIN_P = gain_t'(32'sd1 <<< (FRAC_BITS - 2));
  localparam gain_t RST_GAIN_I = '0;
  localparam gain_t RST_GAIN_D = gain_t'(32'sd30 <<< FRAC_BITS);
  localparam step_t RST_STEP_P = 31'd167772;
  localparam step_t RST_STEP_I = 31'd1678;
  localparam step_t RST_STEP_D = 31'd167772;

  localparam err_t  ERR_INIT = '1;
  localparam step_t STEP_MAX = '1;

  // Reciprocal of 5 for a 32-bit dividend: q = (s * RECIP5) >> RECIP5_SHIFT
  localparam logic [31:0] RECIP5       = 32'hCCCC_CCCD;
  localparam int          RECIP5_SHIFT = 34;

  localparam logic signed [33:0] SUM_MAX = 34'sd2147483647;
  localparam logic signed [33:0] SUM_MIN = -34'sd2147483648;

  typedef struct packed {
    gain_t [NUM_GAINS-1:0] gain;
    step_t [NUM_GAINS-1:0] step;
  } twg_cfg_t;

  typedef struct packed {
    logic vld;
    err_t err;
  } twg_in_t;

  // Clamp a widened gain sum to the signed 32-bit range
  function automatic gain_t sat_gain(input logic signed [33:0] v);
    gain_t res;
    if (v > SUM_MAX) begin
      res = gain_t'(SUM_MAX[31:0]);
    end else if (v < SUM_MIN) begin
      res = gain_t'(SUM_MIN[31:0]);
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // Rounding term of (6*r + 2) / 5 for remainder r of step / 5
  function automatic logic [2:0] grow_frac(input logic [2:0] r);
    logic [2:0] res;
    case (r)
      3'd0:    res = 3'd0;
      3'd1:    res = 3'd1;
      3'd2:    res = 3'd2;
      3'd3:    res = 3'd4;
      3'd4:    res = 3'd5;
      default: res = 3'd0;
    endcase
    return res;
  endfunction

  // Rounding term of (4*r + 2) / 5 for remainder r of step / 5
  function automatic logic [1:0] shrink_frac(input logic [2:0] r);
    logic [1:0] res;
    case (r)
      3'd0:    res = 2'd0;
      3'd1:    res = 2'd1;
      3'd2:    res = 2'd2;
      3'd3:    res = 2'd2;
      3'd4:    res = 2'd3;
      default: res = 2'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* hdl/twg_cfg_regs.sv */
// Configuration register file holding the initial gains and steps.
`default_nettype none

module twg_cfg_regs (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  twg_pkg::reg_idx_t     cfg_idx_i,
  input  twg_pkg::cfg_data_t    cfg_data_i,
  output twg_pkg::twg_cfg_t     cfg_o
);

  twg_pkg::twg_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        twg_pkg::REG_GAIN_P: cfg_d.gain[twg_pkg::GIDX_P] = cfg_data_i;
        twg_pkg::REG_GAIN_I: cfg_d.gain[twg_pkg::GIDX_I] = cfg_data_i;
        twg_pkg::REG_GAIN_D: cfg_d.gain[twg_pkg::GIDX_D] = cfg_data_i;
        twg_pkg::REG_STEP_P: cfg_d.step[twg_pkg::GIDX_P] = cfg_data_i[30:0];
        twg_pkg::REG_STEP_I: cfg_d.step[twg_pkg::GIDX_I] = cfg_data_i[30:0];
        twg_pkg::REG_STEP_D: cfg_d.step[twg_pkg::GIDX_D] = cfg_data_i[30:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain[twg_pkg::GIDX_P] <= twg_pkg::RST_GAIN_P;
      cfg_q.gain[twg_pkg::GIDX_I] <= twg_pkg::RST_GAIN_I;
      cfg_q.gain[twg_pkg::GIDX_D] <= twg_pkg::RST_GAIN_D;
      cfg_q.step[twg_pkg::GIDX_P] <= twg_pkg::RST_STEP_P;
      cfg_q.step[twg_pkg::GIDX_I] <= twg_pkg::RST_STEP_I;
      cfg_q.step[twg_pkg::GIDX_D] <= twg_pkg::RST_STEP_D;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hdl/twg_in_reg.sv */
// Input register stage for measured error transfers.
`default_nettype none

module twg_in_reg (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  twg_pkg::err_t     measured_error_i,
  input  wire               advance_i,
  output twg_pkg::twg_in_t  in_o
);

  logic          vld_q, vld_d;
  twg_pkg::err_t err_q;

  // Free when empty or when the held item moves on this cycle
  assign in_ready_o = !vld_q || advance_i;
  assign vld_d      = in_ready_o ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      err_q <= measured_error_i;
    end
  end

  assign in_o.vld = vld_q;
  assign in_o.err = err_q;

endmodule

`default_nettype wire

/* hdl/twg_step_scale.sv */
// Step scaling: round-to-nearest step*6/5 (saturated) and step*4/5.
`default_nettype none

module twg_step_scale (
  input  twg_pkg::step_t step_i,
  output twg_pkg::step_t grow_o,
  output twg_pkg::step_t shrink_o
);

  logic [62:0] prod;
  logic [28:0] quot;
  logic [30:0] five_q;
  logic [30:0] rem_w;
  logic [2:0]  rem;
  logic [31:0] grow_w;

  // step = 5*quot + rem, then scale quot exactly and fix up the remainder part
  assign prod   = 63'(step_i) * 63'(twg_pkg::RECIP5);
  assign quot   = prod[twg_pkg::RECIP5_SHIFT +: 29];
  assign five_q = {quot, 2'b00} + 31'(quot);
  assign rem_w  = step_i - five_q;
  assign rem    = rem_w[2:0];

  assign grow_w = {1'b0, quot, 2'b00} + {2'b00, quot, 1'b0}
                + 32'(twg_pkg::grow_frac(rem));

  assign grow_o   = grow_w[31] ? twg_pkg::STEP_MAX : grow_w[30:0];
  assign shrink_o = {quot, 2'b00} + 31'(twg_pkg::shrink_frac(rem));

endmodule

`default_nettype wire

/* hdl/twg_core.sv */
// Tuner state, single-pass update logic and result register.
`default_nettype none

module twg_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  twg_pkg::twg_in_t    in_i,
  input  twg_pkg::twg_cfg_t   cfg_i,
  output twg_pkg::step_t      sel_step_o,
  input  twg_pkg::step_t      grow_i,
  input  twg_pkg::step_t      shrink_i,
  output logic                advance_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output twg_pkg::gain_t      next_gain_p_o,
  output twg_pkg::gain_t      next_gain_i_o,
  output twg_pkg::gain_t      next_gain_d_o,
  output twg_pkg::err_t       best_error_o,
  output twg_pkg::gidx_t      tuned_index_o
);

  twg_pkg::gain_t [twg_pkg::NUM_GAINS-1:0] gains_q, gains_d;
  twg_pkg::step_t [twg_pkg::NUM_GAINS-1:0] steps_q, steps_d;
  twg_pkg::err_t   low_q, low_d;
  twg_pkg::gidx_t  gidx_q, gidx_d;
  twg_pkg::phase_t phase_q, phase_d;

  logic                                    out_vld_q, out_vld_d;
  twg_pkg::gain_t [twg_pkg::NUM_GAINS-1:0] res_gain_q;
  twg_pkg::err_t                           res_err_q;
  twg_pkg::gidx_t                          res_idx_q;

  twg_pkg::gidx_t    idx, nxt;
  logic              better;
  logic              restore;
  logic signed [33:0] idx_delta;
  twg_pkg::gain_t    idx_sum, nxt_sum, start_sum;

  // Unused index code behaves as gain zero
  assign idx = (gidx_q == twg_pkg::GIDX_P || gidx_q == twg_pkg::GIDX_I ||
                gidx_q == twg_pkg::GIDX_D) ? gidx_q : twg_pkg::GIDX_P;
  assign nxt = (idx == twg_pkg::GIDX_D) ? twg_pkg::GIDX_P : idx + 2'd1;

  assign better     = in_i.err < low_q;
  assign sel_step_o = steps_q[idx];

  // After minus with no gain: step back up once; after plus with no gain: down twice
  assign restore   = (phase_q == twg_pkg::PH_MINUS);
  assign idx_delta = restore ? $signed({3'b000, steps_q[idx]})
                             : -$signed({2'b00, steps_q[idx], 1'b0});
  assign idx_sum   = twg_pkg::sat_gain(34'(gains_q[idx]) + idx_delta);
  assign nxt_sum   = twg_pkg::sat_gain(34'(gains_q[nxt])
                                       + $signed({3'b000, steps_q[nxt]}));
  assign start_sum = twg_pkg::sat_gain(34'(cfg_i.gain[twg_pkg::GIDX_P])
                         + $signed({3'b000, cfg_i.step[twg_pkg::GIDX_P]}));

  always_comb begin
    gains_d = gains_q;
    steps_d = steps_q;
    low_d   = low_q;
    gidx_d  = idx;
    phase_d = phase_q;
    case (phase_q)
      twg_pkg::PH_PLUS: begin
        if (better) begin
          low_d          = in_i.err;
          steps_d[idx]   = grow_i;
          gains_d[nxt]   = nxt_sum;
          gidx_d         = nxt;
          phase_d        = twg_pkg::PH_PLUS;
        end else begin
          gains_d[idx]   = idx_sum;
          phase_d        = twg_pkg::PH_MINUS;
        end
      end
      twg_pkg::PH_MINUS: begin
        if (better) begin
          low_d          = in_i.err;
          steps_d[idx]   = grow_i;
        end else begin
          gains_d[idx]   = idx_sum;
          steps_d[idx]   = shrink_i;
        end
        gains_d[nxt]     = nxt_sum;
        gidx_d           = nxt;
        phase_d          = twg_pkg::PH_PLUS;
      end
      default: begin
        // Start: drop the measurement, reload from config and raise gain p
        gains_d                   = cfg_i.gain;
        steps_d                   = cfg_i.step;
        gains_d[twg_pkg::GIDX_P]  = start_sum;
        gidx_d                    = twg_pkg::GIDX_P;
        phase_d                   = twg_pkg::PH_PLUS;
      end
    endcase
  end

  assign advance_o = in_i.vld && (!out_vld_q || out_ready_i);
  assign out_vld_d = (!out_vld_q || out_ready_i) ? in_i.vld : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q     <= twg_pkg::ERR_INIT;
      gidx_q    <= twg_pkg::GIDX_P;
      phase_q   <= twg_pkg::PH_START;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (advance_o) begin
        low_q   <= low_d;
        gidx_q  <= gidx_d;
        phase_q <= phase_d;
      end
    end
  end

  // Gains and steps are always reloaded in the start phase before use
  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      gains_q    <= gains_d;
      steps_q    <= steps_d;
      res_gain_q <= gains_d;
      res_err_q  <= low_d;
      res_idx_q  <= gidx_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign next_gain_p_o = res_gain_q[twg_pkg::GIDX_P];
  assign next_gain_i_o = res_gain_q[twg_pkg::GIDX_I];
  assign next_gain_d_o = res_gain_q[twg_pkg::GIDX_D];
  assign best_error_o  = res_err_q;
  assign tuned_index_o = res_idx_q;

endmodule

`default_nettype wire

/* hdl/twiddle_gain_tuner_top.sv */
// Top level of the twiddle coordinate-descent gain tuner.
//
// Usage: each input transfer carries the error score measured with the gain
// set proposed last; each output transfer carries the next gain set to try,
// the best error so far and which gain is being varied. One result per input.
// The first input after reset is discarded: the gains and steps are loaded
// from the configuration registers and gain p is raised by its step.
// Configuration registers 0..5 (initial gains p, i, d, initial steps p, i, d)
// are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write
// them only while the block idles, which the block itself does not enforce.
// The measured error is registered in the input register and the update
// result in the result register, which drives out_valid_o.
// Throughput: one item per cycle while the receiver does not stall; the update
// path is one compare, one 31x32 constant multiply for step scaling and three
// saturating adds side by side between the input and result registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; after that in_ready_o drops until out_ready_i.
// Reset clears the pipeline, sets the best error to all ones, selects gain p,
// enters the start phase and restores the register defaults.
`default_nettype none

module twiddle_gain_tuner_top (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  twg_pkg::reg_idx_t    cfg_idx_i,
  input  twg_pkg::cfg_data_t   cfg_data_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  twg_pkg::err_t        measured_error_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output twg_pkg::gain_t       next_gain_p_o,
  output twg_pkg::gain_t       next_gain_i_o,
  output twg_pkg::gain_t       next_gain_d_o,
  output twg_pkg::err_t        best_error_o,
  output twg_pkg::gidx_t       tuned_index_o
);

  twg_pkg::twg_cfg_t cfg;
  twg_pkg::twg_in_t  in_stage;
  twg_pkg::step_t    sel_step, grow_step, shrink_step;
  logic              advance;

  twg_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  twg_in_reg u_in_reg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .measured_error_i (measured_error_i),
    .advance_i        (advance),
    .in_o             (in_stage)
  );

  twg_step_scale u_step_scale (
    .step_i   (sel_step),
    .grow_o   (grow_step),
    .shrink_o (shrink_step)
  );

  twg_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_stage),
    .cfg_i         (cfg),
    .sel_step_o    (sel_step),
    .grow_i        (grow_step),
    .shrink_i      (shrink_step),
    .advance_o     (advance),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .next_gain_p_o (next_gain_p_o),
    .next_gain_i_o (next_gain_i_o),
    .next_gain_d_o (next_gain_d_o),
    .best_error_o  (best_error_o),
    .tuned_index_o (tuned_index_o)
  );

endmodule

`default_nettype wire
